FILE: hdl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg: shared definitions of the line pixel generator
// Matrix size, queue sizing and the line descriptor that passes from the
// front part to the drawing back part.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int WIDTH  = 16;
    localparam int HEIGHT = 64;

    // Upper bound on pixels emitted for one line.
    localparam int MAX_PIXELS = 64;
    localparam int CNT_W      = $clog2(MAX_PIXELS);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified line command, ready to be drawn.
    typedef struct packed {
        logic [7:0]        start_x;
        logic [7:0]        start_y;
        logic [7:0]        target_x;
        logic [7:0]        target_y;
        logic [7:0]        abs_dx;
        logic signed [8:0] neg_abs_dy;
        logic signed [10:0] error_term;
        logic              step_x_neg;
        logic              step_y_neg;
        logic [7:0]        level;
    } line_desc_t;

    function automatic logic inside_matrix(input logic [7:0] x, input logic [7:0] y);
        inside_matrix = (x < 8'(WIDTH)) && (y < 8'(HEIGHT));
    endfunction

endpackage

FILE: hdl/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front: command intake and classification
// Accepts line commands, derives deltas, step directions and the initial
// error term, and drops commands whose start point lies off the matrix.
// ----------------------------------------------------------------------------
module lpg_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        start_x,
    input  logic [7:0]        start_y,
    input  logic [7:0]        end_x,
    input  logic [7:0]        end_y,
    input  logic [7:0]        level,
    input  logic              queue_full,
    output logic              queue_push,
    output lpg_pkg::line_desc_t desc
);
    import lpg_pkg::*;

    logic       x_up;
    logic       y_up;
    logic [7:0] abs_dy;

    assign x_up   = start_x < end_x;
    assign y_up   = start_y < end_y;
    assign abs_dy = y_up ? (end_y - start_y) : (start_y - end_y);

    always_comb
    begin
        desc.start_x    = start_x;
        desc.start_y    = start_y;
        desc.target_x   = end_x;
        desc.target_y   = end_y;
        desc.abs_dx     = x_up ? (end_x - start_x) : (start_x - end_x);
        desc.neg_abs_dy = -$signed({1'b0, abs_dy});
        desc.error_term = $signed({3'b000, desc.abs_dx}) - $signed({3'b000, abs_dy});
        desc.step_x_neg = !x_up;
        desc.step_y_neg = !y_up;
        desc.level      = level;
    end

    // A command that starts off the matrix is taken and produces nothing.
    assign in_ready   = !queue_full;
    assign queue_push = in_valid && !queue_full && inside_matrix(start_x, start_y);

endmodule

FILE: hdl/lpg_queue.sv
// ----------------------------------------------------------------------------
// lpg_queue: descriptor queue between front and back
// A small register FIFO that lets intake and drawing stall independently.
// ----------------------------------------------------------------------------
module lpg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  lpg_pkg::line_desc_t wr_desc,
    input  logic                push,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output lpg_pkg::line_desc_t rd_desc
);
    import lpg_pkg::*;

    line_desc_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_desc = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_desc;
    end

endmodule

FILE: hdl/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back: Bresenham stepping engine
// Walks one line a pixel per cycle while the output is not stalled, drives
// the registered pixel output and looks one step ahead to mark the final pixel.
// ----------------------------------------------------------------------------
module lpg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lpg_pkg::line_desc_t desc,
    input  logic                queue_empty,
    output logic                queue_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          pixel_x,
    output logic [5:0]          pixel_y,
    output logic [7:0]          pixel_level,
    output logic                last_pixel
);
    import lpg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         cur_x_reg, cur_y_reg;
    logic [7:0]         target_x_reg, target_y_reg;
    logic [7:0]         abs_dx_reg;
    logic signed [8:0]  neg_abs_dy_reg;
    logic signed [10:0] error_term_reg;
    logic               step_x_neg_reg, step_y_neg_reg;
    logic [7:0]         held_level_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    logic signed [11:0] twice;
    logic               x_req, y_req, x_done, y_done, x_step, y_step;
    logic               reached, is_last, fire;
    logic [7:0]         nx, ny;
    logic signed [10:0] err_next;

    assign twice   = {error_term_reg[10], error_term_reg} <<< 1;
    assign x_req   = twice >= 12'(neg_abs_dy_reg);
    assign y_req   = twice <= $signed({4'b0000, abs_dx_reg});
    assign x_done  = x_req && (cur_x_reg == target_x_reg);
    assign y_done  = !x_done && y_req && (cur_y_reg == target_y_reg);
    assign x_step  = x_req && !x_done;
    assign y_step  = !x_done && y_req && !y_done;
    assign reached = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    always_comb
    begin
        nx = cur_x_reg;
        ny = cur_y_reg;
        err_next = error_term_reg;
        if (x_step)
        begin
            nx = step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            err_next = err_next + 11'(neg_abs_dy_reg);
        end
        if (y_step)
        begin
            ny = step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            err_next = err_next + $signed({3'b000, abs_dx_reg});
        end
    end

    // The pixel now emitted is the final one when the next point would not be.
    assign is_last = reached || x_done || y_done || !inside_matrix(nx, ny)
                     || (count_reg == CNT_W'(MAX_PIXELS - 1));
    assign fire      = (state_reg == ST_DRAW) && (!out_valid_reg || out_ready);
    assign queue_pop = (state_reg == ST_IDLE) && !queue_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (!queue_empty)
                    state_next = ST_DRAW;
            ST_DRAW:
                if (fire && is_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (queue_pop)
                count_reg <= '0;
            else if (fire)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            cur_x_reg      <= desc.start_x;
            cur_y_reg      <= desc.start_y;
            target_x_reg   <= desc.target_x;
            target_y_reg   <= desc.target_y;
            abs_dx_reg     <= desc.abs_dx;
            neg_abs_dy_reg <= desc.neg_abs_dy;
            error_term_reg <= desc.error_term;
            step_x_neg_reg <= desc.step_x_neg;
            step_y_neg_reg <= desc.step_y_neg;
            held_level_reg <= desc.level;
        end
        else if (fire)
        begin
            cur_x_reg      <= nx;
            cur_y_reg      <= ny;
            error_term_reg <= err_next;
        end
        if (fire)
        begin
            pixel_x     <= cur_x_reg[5:0];
            pixel_y     <= cur_y_reg[5:0];
            pixel_level <= held_level_reg;
            last_pixel  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;

    // Every point being drawn lies on the matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> inside_matrix(cur_x_reg, cur_y_reg))
        else $error("lpg_back: drawing a point off the matrix");

    // A new line is only taken while no line is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_pop |-> (state_reg == ST_IDLE))
        else $error("lpg_back: line popped while drawing");

    // A pixel issued as final returns the engine to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last) |=> (state_reg == ST_IDLE))
        else $error("lpg_back: engine kept drawing after final pixel");

    // A pixel is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !fire)
        else $error("lpg_back: pending pixel overwritten");

endmodule

FILE: hdl/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator: all-octant Bresenham line to pixel stream
// Turns a line command into the ordered pixels of an integer Bresenham line
// clipped to the WIDTH by HEIGHT matrix, each pixel flagged last or not.
//
//   channel   direction  fields                                    handshake
//   command   in         start_x start_y end_x end_y level         in_valid/in_ready
//   pixel     out        pixel_x pixel_y pixel_level last_pixel    out_valid/out_ready
//
// A line is first picked from the queue in the idle state, then one pixel
// per cycle is emitted while the output is not stalled, at most 64 per line.
// The Bresenham step loop in the back part sets this pace.
// The front takes a command whenever the two-entry queue has room, even
// while the back is drawing or a pixel waits at the output.
// A command starting off the matrix is accepted and yields no pixel.
// Reset clears the queue, the engine state and the output valid.
// ----------------------------------------------------------------------------
module line_pixel_generator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] start_x,
    input  logic [7:0] start_y,
    input  logic [7:0] end_x,
    input  logic [7:0] end_y,
    input  logic [7:0] level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] pixel_x,
    output logic [5:0] pixel_y,
    output logic [7:0] pixel_level,
    output logic       last_pixel
);
    import lpg_pkg::*;

    // Classified command from the front, and the head of the queue.
    line_desc_t front_desc;
    line_desc_t head_desc;

    // Queue handshake: the front writes, the back reads.
    logic       queue_push;
    logic       queue_full;
    logic       queue_pop;
    logic       queue_empty;

    // The front part: classification and early drop of off-matrix starts.
    lpg_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .level      (level),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .desc       (front_desc)
    );

    // The queue decouples intake from drawing.
    lpg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_desc (front_desc),
        .push    (queue_push),
        .full    (queue_full),
        .pop     (queue_pop),
        .empty   (queue_empty),
        .rd_desc (head_desc)
    );

    // The back part steps the line and owns the output register.
    lpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc        (head_desc),
        .queue_empty (queue_empty),
        .queue_pop   (queue_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_level (pixel_level),
        .last_pixel  (last_pixel)
    );

endmodule
